// ----- sv/mesh_blob_parser_macros.svh -----
// assertion macros shared by the mesh blob parser modules
`ifndef MESH_BLOB_PARSER_MACROS_SVH
`define MESH_BLOB_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mbp_pkg.sv -----
// shared types, codes and constants of the mesh blob parser
`default_nettype none

package mbp_pkg;

  localparam int unsigned COUNT_W = 40;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned REC_W   = 33;

  localparam logic [COUNT_W-1:0] MAGIC_LEN      = 40'd8;
  localparam logic [COUNT_W-1:0] POS_VERSION    = 40'd11;
  localparam logic [COUNT_W-1:0] POS_VCOUNT     = 40'd15;
  localparam logic [COUNT_W-1:0] POS_FCOUNT     = 40'd19;
  localparam logic [COUNT_W-1:0] HEADER_BYTES   = 40'd20;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
  localparam logic [WORD_W-1:0]  VERSION_OK     = 32'd1;
  localparam logic [WORD_W-1:0]  LIMIT_RESET    = 32'd200000000;

  // register indexes of the config port
  localparam logic [1:0] CFG_MAX_VERTICES = 2'd0;
  localparam logic [1:0] CFG_MAX_FACETS   = 2'd1;

  // fault flag bit positions
  localparam int unsigned F_MAGIC   = 0;
  localparam int unsigned F_VERSION = 1;
  localparam int unsigned F_TOOMANY = 2;
  localparam int unsigned F_INDEX   = 3;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_FACET  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_TOOMANY = 3'd4,
    ST_LENGTH  = 3'd5,
    ST_INDEX   = 3'd6
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [WORD_W-1:0]  word_a;
    logic [WORD_W-1:0]  word_b;
    logic [WORD_W-1:0]  word_c;
    status_t            status;
    logic               last;
  } res_t;

  // up to two results per byte: a record, then the status
  typedef struct packed {
    logic rec_valid;
    res_t rec;
    logic st_valid;
    res_t st;
  } res_pair_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h45; // E
      3'd1: b = 8'h53; // S
      3'd2: b = 8'h43; // C
      3'd3: b = 8'h55; // U
      3'd4: b = 8'h54; // T
      3'd5: b = 8'h4D; // M
      3'd6: b = 8'h53; // S
      3'd7: b = 8'h48; // H
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mbp_parse.sv -----
// header check, record assembly and final status of the mesh blob parser
`default_nettype none
`include "mesh_blob_parser_macros.svh"

module mbp_parse (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [31:0]               cfg_data,
  input  wire logic                      accept,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      end_of_blob,
  output mbp_pkg::res_pair_t             results
);

  logic [mbp_pkg::WORD_W-1:0]  max_vertices;
  logic [mbp_pkg::WORD_W-1:0]  max_facets;
  logic [mbp_pkg::COUNT_W-1:0] byte_count;
  logic [mbp_pkg::WORD_W-1:0]  word_shift;
  logic [mbp_pkg::WORD_W-1:0]  held_a;
  logic [mbp_pkg::WORD_W-1:0]  held_b;
  logic [mbp_pkg::WORD_W-1:0]  vertex_total;
  logic [mbp_pkg::WORD_W-1:0]  facet_total;
  logic [3:0]                  fault_flags;
  logic [mbp_pkg::COUNT_W-1:0] need;
  logic [1:0]                  slot;
  logic [mbp_pkg::REC_W-1:0]   rec_cnt;

  logic [mbp_pkg::WORD_W-1:0]  ws_next;
  logic [mbp_pkg::COUNT_W-1:0] byte_count_next;
  logic [mbp_pkg::WORD_W-1:0]  held_a_next;
  logic [mbp_pkg::WORD_W-1:0]  held_b_next;
  logic [mbp_pkg::WORD_W-1:0]  vertex_total_next;
  logic [mbp_pkg::WORD_W-1:0]  facet_total_next;
  logic [3:0]                  fault_flags_next;
  logic [mbp_pkg::COUNT_W-1:0] need_next;
  logic [1:0]                  slot_next;
  logic [mbp_pkg::REC_W-1:0]   rec_cnt_next;
  logic [mbp_pkg::REC_W-1:0]   count_sum;
  logic [mbp_pkg::COUNT_W-1:0] need_calc;
  logic                        in_body;
  logic                        word_done;
  logic                        bad_index;
  mbp_pkg::status_t            st_code;

  assign ws_next   = {data_byte, word_shift[31:8]};
  assign word_done = (byte_count[1:0] == 2'd3);
  assign in_body   = (byte_count >= mbp_pkg::HEADER_BYTES) && (byte_count < need)
                     && (fault_flags == 4'd0);
  assign bad_index = (held_a >= vertex_total) || (held_b >= vertex_total)
                     || (ws_next >= vertex_total);

  // expected blob length: 20 + 12 * (vertices + facets)
  assign count_sum = {1'b0, vertex_total} + {1'b0, ws_next};
  assign need_calc = mbp_pkg::HEADER_BYTES + {4'd0, count_sum, 3'd0}
                     + {5'd0, count_sum, 2'd0};

  always_comb begin
    held_a_next       = held_a;
    held_b_next       = held_b;
    vertex_total_next = vertex_total;
    facet_total_next  = facet_total;
    fault_flags_next  = fault_flags;
    need_next         = need;
    slot_next         = slot;
    rec_cnt_next      = rec_cnt;
    results           = '0;

    if (byte_count < mbp_pkg::MAGIC_LEN) begin
      if (data_byte != mbp_pkg::magic_byte(byte_count[2:0])) begin
        fault_flags_next[mbp_pkg::F_MAGIC] = 1'b1;
      end
    end else if (byte_count == mbp_pkg::POS_VERSION) begin
      if (ws_next != mbp_pkg::VERSION_OK) begin
        fault_flags_next[mbp_pkg::F_VERSION] = 1'b1;
      end
    end else if (byte_count == mbp_pkg::POS_VCOUNT) begin
      vertex_total_next = ws_next;
    end else if (byte_count == mbp_pkg::POS_FCOUNT) begin
      facet_total_next = ws_next;
      need_next        = need_calc;
      if ((vertex_total > max_vertices) || (ws_next > max_facets)) begin
        fault_flags_next[mbp_pkg::F_TOOMANY] = 1'b1;
      end
    end else if (in_body && word_done) begin
      if (slot == 2'd0) begin
        held_a_next = ws_next;
      end else if (slot == 2'd1) begin
        held_b_next = ws_next;
      end else if (rec_cnt < {1'b0, vertex_total}) begin
        results.rec_valid = 1'b1;
        results.rec.kind  = mbp_pkg::KIND_VERTEX;
      end else if (bad_index) begin
        fault_flags_next[mbp_pkg::F_INDEX] = 1'b1;
      end else begin
        results.rec_valid = 1'b1;
        results.rec.kind  = mbp_pkg::KIND_FACET;
      end
    end
    results.rec.word_a = held_a;
    results.rec.word_b = held_b;
    results.rec.word_c = ws_next;
    results.rec.status = mbp_pkg::ST_OK;
    results.rec.last   = 1'b0;

    // record slot tracking; only meaningful inside the body
    if ((byte_count >= mbp_pkg::HEADER_BYTES) && word_done) begin
      if (slot == 2'd2) begin
        slot_next    = 2'd0;
        rec_cnt_next = rec_cnt + 1'b1;
      end else begin
        slot_next = slot + 2'd1;
      end
    end

    byte_count_next = (byte_count != mbp_pkg::COUNT_MAX) ? byte_count + 1'b1 : byte_count;

    if (byte_count_next < mbp_pkg::HEADER_BYTES) begin
      st_code = mbp_pkg::ST_SHORT;
    end else if (fault_flags_next[mbp_pkg::F_MAGIC]) begin
      st_code = mbp_pkg::ST_MAGIC;
    end else if (fault_flags_next[mbp_pkg::F_VERSION]) begin
      st_code = mbp_pkg::ST_VERSION;
    end else if (fault_flags_next[mbp_pkg::F_TOOMANY]) begin
      st_code = mbp_pkg::ST_TOOMANY;
    end else if (byte_count_next != need_next) begin
      st_code = mbp_pkg::ST_LENGTH;
    end else if (fault_flags_next[mbp_pkg::F_INDEX]) begin
      st_code = mbp_pkg::ST_INDEX;
    end else begin
      st_code = mbp_pkg::ST_OK;
    end
    results.st_valid  = end_of_blob;
    results.st.kind   = mbp_pkg::KIND_STATUS;
    results.st.word_a = '0;
    results.st.word_b = '0;
    results.st.word_c = '0;
    results.st.status = st_code;
    results.st.last   = 1'b1;

    if (!accept) begin
      results.rec_valid = 1'b0;
      results.st_valid  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_vertices <= mbp_pkg::LIMIT_RESET;
      max_facets   <= mbp_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == mbp_pkg::CFG_MAX_VERTICES) begin
        max_vertices <= cfg_data;
      end else if (cfg_index == mbp_pkg::CFG_MAX_FACETS) begin
        max_facets <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      word_shift   <= '0;
      vertex_total <= '0;
      facet_total  <= '0;
      fault_flags  <= '0;
      need         <= mbp_pkg::HEADER_BYTES;
      slot         <= '0;
      rec_cnt      <= '0;
    end else if (accept) begin
      if (end_of_blob) begin
        byte_count   <= '0;
        word_shift   <= '0;
        vertex_total <= '0;
        facet_total  <= '0;
        fault_flags  <= '0;
        need         <= mbp_pkg::HEADER_BYTES;
        slot         <= '0;
        rec_cnt      <= '0;
      end else begin
        byte_count   <= byte_count_next;
        word_shift   <= ws_next;
        vertex_total <= vertex_total_next;
        facet_total  <= facet_total_next;
        fault_flags  <= fault_flags_next;
        need         <= need_next;
        slot         <= slot_next;
        rec_cnt      <= rec_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_a <= held_a_next;
      held_b <= held_b_next;
    end
  end

  `MBP_ASSERT_NEXT(a_clear_on_end, accept && end_of_blob, (byte_count == '0) && (fault_flags == 4'd0), "blob state not cleared after last byte")
  `MBP_ASSERT_NOW(a_no_record_after_fault, results.rec_valid, fault_flags == 4'd0, "record emitted after a fault")
  `MBP_ASSERT_NOW(a_status_on_last, results.st_valid, accept && end_of_blob, "status without a last byte")

endmodule

`default_nettype wire

// ----- sv/mbp_outq.sv -----
// four-entry result queue, takes up to two results per cycle
`default_nettype none
`include "mesh_blob_parser_macros.svh"

module mbp_outq (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mbp_pkg::res_pair_t push,
  output logic             space,
  output logic             out_valid,
  input  wire logic        out_ready,
  output mbp_pkg::res_t    out_res
);

  mbp_pkg::res_t q [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic [1:0] st_ptr;
  logic [1:0] n_push;
  logic       pop;

  assign space     = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign out_res   = q[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign n_push    = {1'b0, push.rec_valid} + {1'b0, push.st_valid};
  assign st_ptr    = push.rec_valid ? wr_ptr + 2'd1 : wr_ptr;
  assign count_next = count + {1'b0, n_push} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.rec_valid) begin
      q[wr_ptr] <= push.rec;
    end
    if (push.st_valid) begin
      q[st_ptr] <= push.st;
    end
  end

  `MBP_ASSERT_NOW(a_count_bound, 1'b1, count <= 3'd4, "queue count beyond depth")
  `MBP_ASSERT_NOW(a_no_overrun, push.rec_valid || push.st_valid, count <= 3'd2, "push without room")
  `MBP_ASSERT_NEXT(a_pair_lands, push.rec_valid && push.st_valid && !pop, count == $past(count) + 3'd2, "pair push not counted")

endmodule

`default_nettype wire

// ----- sv/mesh_blob_parser.sv -----
// top level of the mesh blob parser: stream ports, config port, parse and queue
//
//  channel | dir | tdata (low bit up)                      | tuser       | tlast
//  s_axis  | in  | data_byte[7:0]                          | -           | end_of_blob
//  m_axis  | out | word_a, word_b, word_c, status, 5'b0 pad | record_kind | last_of_run
//  cfg     | in  | cfg_index 0 max_vertices, 1 max_facets; cfg_data 32 bits
//
// one byte per cycle while s_axis_tready is high; each byte is parsed in the cycle
// it is taken and its results land in a four-entry queue that feeds the output port
// a byte that ends a record and the blob gives two results, record first
// s_axis_tready drops while fewer than two queue entries are free
// rst is synchronous; limits return to 200000000 and the blob state clears
`default_nettype none

module mesh_blob_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // data_byte
  input  wire logic         s_axis_tlast,   // end_of_blob
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [103:0]      m_axis_tdata,   // word_a, word_b, word_c, status, zero pad
  output logic [1:0]        m_axis_tuser,   // record_kind
  output logic              m_axis_tlast    // last_of_run
);

  mbp_pkg::res_pair_t results;
  mbp_pkg::res_t      out_res;
  logic               space;
  logic               accept;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  mbp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .data_byte   (s_axis_tdata),
    .end_of_blob (s_axis_tlast),
    .results     (results)
  );

  mbp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (results),
    .space     (space),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.status, out_res.word_c, out_res.word_b, out_res.word_a};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire
